@@ src/md5_pkg.sv @@
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FIN,
        ST_OUT
    } t_state;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

endpackage

@@ src/md5_message_digest_top.sv @@
// MD5 digest over a byte stream.
// Input channel (i_valid/o_ready): one word per item with i_data_byte, i_byte_present
// and i_message_end. An item with a byte writes it into the 64-byte block buffer;
// the 64th byte of a block starts a compression of 64 rounds, one round
// per cycle through a single round unit, then a fold into the chain.
// o_ready is low while the block pads, compresses or outputs.
// At message end the block writes 0x80, zero padding and the 64-bit length one
// byte a cycle, compresses one or two blocks, then sends 16 digest bytes on the
// output channel (o_valid/i_ready), byte 0 first, o_digest_last on the final.
// A stalled receiver holds the current digest byte; nothing else advances.
// 0x80 at offset 56 or later needs a second block for the length.
// Reset restores the initial chaining values and a zero bit count; the buffer
// needs no clearing. After the digest the chain and count return to reset state.
module md5_message_digest_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_message_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_digest_byte,
    output logic       o_digest_last
);
    md5_pkg::t_state r_state, n_state;
    logic [31:0] r_mem [0:15];
    logic [63:0] r_cnt, n_cnt;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_pos, n_pos;
    logic        r_fin, n_fin;
    logic        r_pad, n_pad;
    logic        r_done, n_done;
    logic        r_lenblk, n_lenblk;
    logic [5:0]  r_rnd, n_rnd;
    logic [3:0]  r_oidx, n_oidx;
    logic [31:0] r_h [0:3];
    logic [31:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [3:0]  g;
    logic [31:0] w;
    logic [31:0] rnd_b;
    logic        ld_chain, upd_chain, rst_chain;
    logic [31:0] dword;
    logic [1:0]  oword;

    always_comb begin
        case (r_rnd[5:4])
            2'd0:    g = r_rnd[3:0];
            2'd1:    g = 4'(5 * r_rnd[3:0] + 1);
            2'd2:    g = 4'(3 * r_rnd[3:0] + 5);
            default: g = 4'(7 * r_rnd[3:0]);
        endcase
    end

    assign w = r_mem[g];

    md5_round u_round (
        .i_idx (r_rnd),
        .i_a   (r_a),
        .i_b   (r_b),
        .i_c   (r_c),
        .i_d   (r_d),
        .i_w   (w),
        .o_b   (rnd_b)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_pos     = r_pos;
        n_fin     = r_fin;
        n_pad     = r_pad;
        n_done    = r_done;
        n_lenblk  = r_lenblk;
        n_rnd     = r_rnd;
        n_oidx    = r_oidx;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = 8'h00;
        ld_chain  = 1'b0;
        upd_chain = 1'b0;
        rst_chain = 1'b0;
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        case (r_state)
            md5_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_byte_present) begin
                        wr_en   = 1'b1;
                        wr_addr = r_cnt[8:3];
                        wr_data = i_data_byte;
                        n_cnt   = r_cnt + 64'd8;
                    end
                    n_len = i_byte_present ? r_cnt + 64'd8 : r_cnt;
                    n_pos = i_byte_present ? r_cnt[8:3] + 6'd1 : r_cnt[8:3];
                    if (i_message_end) begin
                        n_fin  = 1'b1;
                        n_pad  = 1'b1;
                        n_done = 1'b0;
                    end
                    if (i_byte_present && r_cnt[8:3] == 6'd63) begin
                        ld_chain = 1'b1;
                        n_rnd    = '0;
                        n_state  = md5_pkg::ST_COMP;
                    end else if (i_message_end) begin
                        n_state = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_PAD: begin
                wr_en = 1'b1;
                if (r_fin) begin
                    wr_data  = 8'h80;
                    n_fin    = 1'b0;
                    n_lenblk = r_pos < 6'd56;
                end else if (r_lenblk && r_pos >= 6'd56) begin
                    wr_data = r_len[{r_pos[2:0], 3'b000} +: 8];
                end
                n_pos = r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    if (!r_fin && r_lenblk) begin
                        n_done = 1'b1;
                    end
                    ld_chain = 1'b1;
                    n_rnd    = '0;
                    n_state  = md5_pkg::ST_COMP;
                end
            end
            md5_pkg::ST_COMP: begin
                n_a   = r_d;
                n_d   = r_c;
                n_c   = r_b;
                n_b   = rnd_b;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = md5_pkg::ST_FIN;
                end
            end
            md5_pkg::ST_FIN: begin
                upd_chain = 1'b1;
                if (!r_pad) begin
                    n_state = md5_pkg::ST_IDLE;
                end else if (!r_done) begin
                    // length did not fit: a second padding block follows
                    n_lenblk = 1'b1;
                    n_state  = md5_pkg::ST_PAD;
                end else begin
                    n_oidx  = '0;
                    n_state = md5_pkg::ST_OUT;
                end
            end
            md5_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_oidx = r_oidx + 4'd1;
                    if (r_oidx == 4'd15) begin
                        rst_chain = 1'b1;
                        n_cnt     = '0;
                        n_pad     = 1'b0;
                        n_done    = 1'b0;
                        n_state   = md5_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = md5_pkg::ST_IDLE;
        endcase
    end

    assign oword = r_oidx[3:2];
    always_comb begin
        case (oword)
            2'd0:    dword = r_h[0];
            2'd1:    dword = r_h[1];
            2'd2:    dword = r_h[2];
            default: dword = r_h[3];
        endcase
    end
    assign o_digest_byte = dword[{r_oidx[1:0], 3'b000} +: 8];
    assign o_digest_last = (r_oidx == 4'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= md5_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_rnd    <= '0;
            r_oidx   <= '0;
            r_pad    <= 1'b0;
            r_done   <= 1'b0;
            r_lenblk <= 1'b0;
            r_h[0]   <= md5_pkg::INIT_A;
            r_h[1]   <= md5_pkg::INIT_B;
            r_h[2]   <= md5_pkg::INIT_C;
            r_h[3]   <= md5_pkg::INIT_D;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_fin    <= n_fin;
            r_rnd    <= n_rnd;
            r_oidx   <= n_oidx;
            r_pad    <= n_pad;
            r_done   <= n_done;
            r_lenblk <= n_lenblk;
            if (rst_chain) begin
                r_h[0] <= md5_pkg::INIT_A;
                r_h[1] <= md5_pkg::INIT_B;
                r_h[2] <= md5_pkg::INIT_C;
                r_h[3] <= md5_pkg::INIT_D;
            end else if (upd_chain) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_pos <= n_pos;
        if (ld_chain) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
        if (wr_en) begin
            r_mem[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("digest output overlaps input acceptance");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == md5_pkg::ST_COMP && r_rnd == 6'd63) |=> r_state == md5_pkg::ST_FIN)
        else $error("compression did not end after 64 rounds");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_last) |=> (r_cnt == 64'd0 && !o_valid))
        else $error("state not restored after digest");
endmodule

@@ src/md5_round.sv @@
module md5_round (
    input  logic [5:0]  i_idx,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_w,
    output logic [31:0] o_b
);
    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] dbl;
    logic [4:0]  s;

    always_comb begin
        case (i_idx[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_b & i_d) | (i_c & ~i_d);
            2'd2:    f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
        t   = i_a + f + i_w + md5_pkg::round_k(i_idx);
        s   = md5_pkg::rot_amount(i_idx);
        dbl = {t, t} << s;
        o_b = i_b + dbl[63:32];
    end
endmodule
